>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication checked with overlapping timing.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rlps_pkg.sv
// ----------------------------------------------------------------------------
// rlps_pkg
// Types and constants for the LED pulse width serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlps_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int SEG_W          = 6;

    localparam logic [SEG_W-1:0] SEG_LAST_BIT = SEG_W'(2 * BITS_PER_PIXEL - 1);
    localparam logic [SEG_W-1:0] SEG_LATCH    = SEG_W'(2 * BITS_PER_PIXEL);

    localparam logic [1:0] REG_LONG  = 2'd0;
    localparam logic [1:0] REG_SHORT = 2'd1;
    localparam logic [1:0] REG_LATCH = 2'd2;

    localparam logic [7:0]  LONG_RESET  = 8'd65;
    localparam logic [7:0]  SHORT_RESET = 8'd15;
    localparam logic [15:0] LATCH_RESET = 16'd50000;

    typedef struct packed {
        logic [BITS_PER_PIXEL-1:0] bits;
        logic                      eof;
    } pixel_t;

    typedef struct packed {
        logic [7:0]  long_ticks;
        logic [7:0]  short_ticks;
        logic [15:0] latch_ticks;
    } cfg_t;

endpackage

`default_nettype wire

>>> sv/rgb_led_pulse_width_serializer_top.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_width_serializer_top
// Pixel to pulse-width segment serializer for single-wire RGB LED strings.
//
//  Channel   Dir  tdata (low bit up)                tuser   tlast
//  s_axis    in   red[7:0] green[15:8] blue[23:16]  -       end_of_frame
//  m_axis    out  duration[15:0]                    level   run_last
//  cfg       in   cfg_index: 0 long, 1 short, 2 latch; cfg_wdata[15:0]
//
//  One segment per cycle unless m_axis stalls: 48 per pixel, 49 with end of
//  frame, set by the back-end serializer counter. Pixels stream back to back.
//  Input register plus a two-entry queue absorb requests while it runs.
//  Output is registered; downstream stalls hold the serializer, then back up.
//  Reset restores the timing registers; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_pulse_width_serializer_top
    import rlps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red, green, blue
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // duration
    output logic             m_axis_tuser,   // level
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    logic   push_valid;
    logic   push_ready;
    pixel_t push_data;
    logic   pop_valid;
    logic   pop;
    pixel_t pop_data;
    cfg_t   cfg;

    rlps_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data),
        .cfg           (cfg)
    );

    rlps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    rlps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .pop_valid     (pop_valid),
        .pop           (pop),
        .pop_data      (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> sv/rlps_front.sv
// ----------------------------------------------------------------------------
// rlps_front
// Input stage: takes pixel requests, orders bits for MSB-first send, holds
// the timing registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlps_front
    import rlps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    output logic             push_valid,
    input  wire logic        push_ready,
    output pixel_t           push_data,
    output cfg_t             cfg
);

    pixel_t hold_reg;
    logic   hold_valid_reg;
    logic   hold_valid_next;
    cfg_t   cfg_reg;
    logic   s_acc;

    assign s_axis_tready = !hold_valid_reg || push_ready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign push_valid    = hold_valid_reg;
    assign push_data     = hold_reg;
    assign cfg           = cfg_reg;

    always_comb
    begin
        if (s_acc)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // red goes out first, so it takes the top bits
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            hold_reg.bits <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
            hold_reg.eof  <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_ticks  <= LONG_RESET;
            cfg_reg.short_ticks <= SHORT_RESET;
            cfg_reg.latch_ticks <= LATCH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LONG:  cfg_reg.long_ticks  <= cfg_wdata[7:0];
                REG_SHORT: cfg_reg.short_ticks <= cfg_wdata[7:0];
                REG_LATCH: cfg_reg.latch_ticks <= cfg_wdata;
                default:   cfg_reg             <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/rlps_queue.sv
// ----------------------------------------------------------------------------
// rlps_queue
// Two-entry pixel FIFO between the input stage and the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rlps_queue
    import rlps_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire pixel_t push_data,
    output logic        pop_valid,
    input  wire logic   pop,
    output pixel_t      pop_data
);

    pixel_t     mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_CLK(a_count_range, count_reg != 2'd3, "queue count out of range")
    `ASSERT_IMP(a_ptr_match, count_reg == 2'd0 || count_reg == 2'd2,
                wr_ptr_reg == rd_ptr_reg, "queue pointers disagree with count")

endmodule

`default_nettype wire

>>> sv/rlps_back.sv
// ----------------------------------------------------------------------------
// rlps_back
// Serializer: turns a pixel into high/low segments, one per cycle unless the
// output stalls, plus the latch segment at end of frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rlps_back
    import rlps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        pop_valid,
    output logic             pop,
    input  wire pixel_t      pop_data,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    logic                      busy_reg;
    logic                      busy_next;
    logic [BITS_PER_PIXEL-1:0] word_reg;
    logic [BITS_PER_PIXEL-1:0] word_next;
    logic                      eof_reg;
    logic                      eof_next;
    logic [SEG_W-1:0]          seg_reg;
    logic [SEG_W-1:0]          seg_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_level_reg;
    logic [15:0]               out_dur_reg;
    logic                      out_last_reg;
    logic                      adv;
    logic                      emit;
    logic                      done;
    logic                      is_latch;
    logic                      seg_level;
    logic [15:0]               seg_dur;
    logic                      seg_last;
    logic [7:0]                long_or_short;

    assign adv      = !out_valid_reg || m_axis_tready;
    assign emit     = busy_reg && adv;
    assign is_latch = (seg_reg == SEG_LATCH);
    assign done     = is_latch || ((seg_reg == SEG_LAST_BIT) && !eof_reg);
    assign pop      = pop_valid && (!busy_reg || (emit && done));

    // even segments are the high part of a bit, odd the low part
    assign seg_level     = !is_latch && !seg_reg[0];
    assign long_or_short = (word_reg[BITS_PER_PIXEL-1] == seg_level) ? cfg.long_ticks
                                                                     : cfg.short_ticks;
    assign seg_dur       = is_latch ? cfg.latch_ticks : {8'd0, long_or_short};
    assign seg_last      = done;

    always_comb
    begin
        busy_next      = busy_reg;
        word_next      = word_reg;
        eof_next       = eof_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (emit)
        begin
            out_valid_next = 1'b1;
            seg_next       = seg_reg + SEG_W'(1);
            if (seg_reg[0])
            begin
                word_next = {word_reg[BITS_PER_PIXEL-2:0], 1'b0};
            end
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            busy_next = 1'b1;
            word_next = pop_data.bits;
            eof_next  = pop_data.eof;
            seg_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            seg_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            seg_reg       <= seg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        eof_reg  <= eof_next;
        if (emit)
        begin
            out_level_reg <= seg_level;
            out_dur_reg   <= seg_dur;
            out_last_reg  <= seg_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_dur_reg;
    assign m_axis_tuser  = out_level_reg;
    assign m_axis_tlast  = out_last_reg;

    `ASSERT_IMP(a_seg_range, busy_reg, seg_reg <= SEG_LATCH, "segment index past latch")
    `ASSERT_IMP(a_latch_eof, busy_reg && is_latch, eof_reg, "latch without end of frame")
    `ASSERT_NEXT(a_finish_idle, emit && done && !pop_valid, !busy_reg,
                 "serializer still busy after final segment")

endmodule

`default_nettype wire
